/* sv/tsi_pkg.sv */
package tsi_pkg;

    localparam int POS_W           = 32;
    localparam int HD_W            = 16;
    localparam int SYM_W           = 8;
    localparam int STACK_DEPTH     = 64;
    localparam int DEPTH_W         = $clog2(STACK_DEPTH + 1);
    localparam int SINE_TABLE_BITS = 10;
    localparam int IDX_W           = SINE_TABLE_BITS;
    localparam int QN              = 1 << (SINE_TABLE_BITS - 2);
    localparam int KW              = IDX_W - 1;
    localparam int SIN_MAG_W       = 17;
    localparam int SIN_W           = SIN_MAG_W + 1;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 32;

    localparam logic [HD_W-1:0]  TURN_STEP_RESET = 16'd8192;
    localparam logic [POS_W-1:0] POS_MAX         = 32'h7FFF_FFFF;
    localparam logic [POS_W-1:0] POS_MIN         = 32'h8000_0000;

    localparam logic [SYM_W-1:0] SYM_A     = 8'h41;
    localparam logic [SYM_W-1:0] SYM_Z     = 8'h5A;
    localparam logic [SYM_W-1:0] SYM_PLUS  = 8'h2B;
    localparam logic [SYM_W-1:0] SYM_MINUS = 8'h2D;
    localparam logic [SYM_W-1:0] SYM_PUSH  = 8'h5B;
    localparam logic [SYM_W-1:0] SYM_POP   = 8'h5D;

    localparam logic [CFG_IDX_W-1:0] CFG_TURN_STEP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_X   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_Y   = 2'd2;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_PUSH_FULL = 2'd1,
        STATUS_POP_EMPTY = 2'd2,
        STATUS_SAT       = 2'd3
    } status_t;

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             first;
    } item_t;

    typedef struct packed {
        logic                    drew;
        logic signed [POS_W-1:0] from_x;
        logic signed [POS_W-1:0] from_y;
        logic signed [POS_W-1:0] to_x;
        logic signed [POS_W-1:0] to_y;
        status_t                 status;
    } result_t;

    typedef struct packed {
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
        logic [HD_W-1:0]  hd;
    } turtle_state_t;

    typedef struct packed {
        logic push;
        logic pop;
    } stack_ctl_t;

    localparam longint unsigned ONE_Q30     = 64'd1 << 30;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    // Quarter-wave sine magnitude for k in 0..QN, Q16; elaboration only.
    function automatic logic [SIN_MAG_W-1:0] quarter_sine(input int unsigned k);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned r;
        longint unsigned v;
        x  = (HALF_PI_Q30 * 64'(k)) >> (SINE_TABLE_BITS - 2);
        x2 = (x * x) >> 30;
        r  = ONE_Q30;
        r  = ONE_Q30 - ((x2 * r) >> 30) / 110;
        r  = ONE_Q30 - ((x2 * r) >> 30) / 72;
        r  = ONE_Q30 - ((x2 * r) >> 30) / 42;
        r  = ONE_Q30 - ((x2 * r) >> 30) / 20;
        r  = ONE_Q30 - ((x2 * r) >> 30) / 6;
        v  = (((x * r) >> 30) + 64'd8192) >> 14;
        if (v > 64'd65536)
        begin
            v = 64'd65536;
        end
        return v[SIN_MAG_W-1:0];
    endfunction

endpackage

/* sv/tsi_sine_lut.sv */
// Signed Q16 sine from a quarter-wave table, folded by quadrant.
module tsi_sine_lut (
    input  logic [tsi_pkg::IDX_W-1:0]        idx,
    output logic signed [tsi_pkg::SIN_W-1:0] value
);

    localparam logic [tsi_pkg::SIN_MAG_W-1:0] QSINE_TOP =
        tsi_pkg::quarter_sine(tsi_pkg::QN);

    logic [tsi_pkg::SIN_MAG_W-1:0] quarter_w [tsi_pkg::QN];
    logic [1:0]                    quad;
    logic [tsi_pkg::KW-2:0]        phase;
    logic [tsi_pkg::KW-1:0]        k;
    logic [tsi_pkg::SIN_MAG_W-1:0] mag;

    for (genvar gi = 0; gi < tsi_pkg::QN; gi++)
    begin : g_tbl
        localparam logic [tsi_pkg::SIN_MAG_W-1:0] VAL = tsi_pkg::quarter_sine(gi);
        assign quarter_w[gi] = VAL;
    end

    assign quad  = idx[tsi_pkg::IDX_W-1 -: 2];
    assign phase = idx[tsi_pkg::KW-2:0];

    always_comb
    begin
        // Mirror odd quadrants; k reaches QN only there.
        if (quad[0])
        begin
            k = tsi_pkg::KW'(tsi_pkg::QN) - {1'b0, phase};
        end
        else
        begin
            k = {1'b0, phase};
        end
        if (k[tsi_pkg::KW-1])
        begin
            mag = QSINE_TOP;
        end
        else
        begin
            mag = quarter_w[k[tsi_pkg::KW-2:0]];
        end
        if (quad[1])
        begin
            value = -$signed({1'b0, mag});
        end
        else
        begin
            value = $signed({1'b0, mag});
        end
    end

endmodule

/* sv/tsi_stack_cell.sv */
// One stack slot: load from the slot above on push, from below on pop.
module tsi_stack_cell (
    input  logic                   clk,
    input  tsi_pkg::stack_ctl_t    ctl,
    input  tsi_pkg::turtle_state_t above,
    input  tsi_pkg::turtle_state_t below,
    output tsi_pkg::turtle_state_t entry
);

    tsi_pkg::turtle_state_t entry_reg;
    tsi_pkg::turtle_state_t entry_next;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.push)
        begin
            entry_next = above;
        end
        else if (ctl.pop)
        begin
            entry_next = below;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

/* sv/turtle_symbol_interpreter.sv */
// Turtle interpreter for L-system symbol streams. Each input word carries one
// symbol; every accepted word yields exactly one result word. Letters A..Z step
// the turtle one unit (cos to x, sin to y, Q16.16) and report the segment,
// '+'/'-' turn by turn_step, '[' saves and ']' restores position and heading,
// anything else passes with status 0. Setting first restarts the turtle at
// start_x/start_y, heading 0, empty stack, before the symbol acts. Status
// flags a dropped push (stack full), an ignored pop (stack empty) or a
// clamped position. Rate: one symbol per clock while the output side keeps up,
// with the result registered; the rate is set by the combinational position
// update (sine table read, 33-bit add, clamp) that each step feeds to the next.
// The save stack is a shift chain of STACK_DEPTH cells whose top is always
// cell 0, so a restore needs no memory read and keeps that rate. The result
// register is released the same cycle it is taken, so the input never stalls
// while the output side keeps up. Config writes take effect at once; start
// position only matters at the next restart.
module turtle_symbol_interpreter (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               item_valid,
    output logic                               item_ready,
    input  tsi_pkg::item_t                     item,
    output logic                               result_valid,
    input  logic                               result_ready,
    output tsi_pkg::result_t                   result,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [tsi_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tsi_pkg::CFG_DATA_W-1:0]     cfg_data
);

    // Configuration registers
    logic [tsi_pkg::HD_W-1:0]  turn_step_reg;
    logic [tsi_pkg::POS_W-1:0] start_x_reg;
    logic [tsi_pkg::POS_W-1:0] start_y_reg;

    // Turtle state
    logic [tsi_pkg::POS_W-1:0]   pos_x_reg, pos_x_next;
    logic [tsi_pkg::POS_W-1:0]   pos_y_reg, pos_y_next;
    logic [tsi_pkg::HD_W-1:0]    heading_reg, heading_next;
    logic [tsi_pkg::DEPTH_W-1:0] depth_reg, depth_next;

    // Output stage
    logic              result_valid_reg, result_valid_next;
    tsi_pkg::result_t  result_reg, result_next;

    logic                         item_accept;
    logic [tsi_pkg::POS_W-1:0]    base_x;
    logic [tsi_pkg::POS_W-1:0]    base_y;
    logic [tsi_pkg::HD_W-1:0]     base_hd;
    logic [tsi_pkg::DEPTH_W-1:0]  base_depth;
    logic [tsi_pkg::IDX_W-1:0]    sin_idx;
    logic [tsi_pkg::IDX_W-1:0]    cos_idx;
    logic signed [tsi_pkg::SIN_W-1:0] sin_w;
    logic signed [tsi_pkg::SIN_W-1:0] cos_w;
    logic [tsi_pkg::POS_W:0]      sum_x;
    logic [tsi_pkg::POS_W:0]      sum_y;
    logic [tsi_pkg::POS_W-1:0]    new_x;
    logic [tsi_pkg::POS_W-1:0]    new_y;
    logic                         sat;
    logic                         is_draw;
    logic                         is_plus;
    logic                         is_minus;
    logic                         is_push;
    logic                         is_pop;
    logic                         stack_full;
    logic                         stack_empty;
    tsi_pkg::stack_ctl_t          stack_ctl;
    tsi_pkg::turtle_state_t       push_state;
    tsi_pkg::turtle_state_t       cell_entry [tsi_pkg::STACK_DEPTH];

    assign cfg_ready    = 1'b1;
    assign item_ready   = !result_valid_reg || result_ready;
    assign item_accept  = item_valid && item_ready;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // Restart folds in ahead of the symbol.
    assign base_x     = item.first ? start_x_reg : pos_x_reg;
    assign base_y     = item.first ? start_y_reg : pos_y_reg;
    assign base_hd    = item.first ? '0 : heading_reg;
    assign base_depth = item.first ? '0 : depth_reg;

    // Table index is the top bits of the heading; cosine leads by a quarter turn.
    assign sin_idx = base_hd[tsi_pkg::HD_W-1 -: tsi_pkg::IDX_W];
    assign cos_idx = sin_idx + tsi_pkg::IDX_W'(tsi_pkg::QN);

    tsi_sine_lut u_sin (
        .idx   (sin_idx),
        .value (sin_w)
    );

    tsi_sine_lut u_cos (
        .idx   (cos_idx),
        .value (cos_w)
    );

    // Step with one guard bit; clamp per axis when the guard disagrees.
    assign sum_x = {base_x[tsi_pkg::POS_W-1], base_x}
                 + {{(tsi_pkg::POS_W + 1 - tsi_pkg::SIN_W){cos_w[tsi_pkg::SIN_W-1]}}, cos_w};
    assign sum_y = {base_y[tsi_pkg::POS_W-1], base_y}
                 + {{(tsi_pkg::POS_W + 1 - tsi_pkg::SIN_W){sin_w[tsi_pkg::SIN_W-1]}}, sin_w};

    always_comb
    begin
        sat = 1'b0;
        new_x = sum_x[tsi_pkg::POS_W-1:0];
        new_y = sum_y[tsi_pkg::POS_W-1:0];
        if (sum_x[tsi_pkg::POS_W] != sum_x[tsi_pkg::POS_W-1])
        begin
            sat   = 1'b1;
            new_x = sum_x[tsi_pkg::POS_W] ? tsi_pkg::POS_MIN : tsi_pkg::POS_MAX;
        end
        if (sum_y[tsi_pkg::POS_W] != sum_y[tsi_pkg::POS_W-1])
        begin
            sat   = 1'b1;
            new_y = sum_y[tsi_pkg::POS_W] ? tsi_pkg::POS_MIN : tsi_pkg::POS_MAX;
        end
    end

    // Symbol decode
    always_comb
    begin
        is_draw  = (item.symbol >= tsi_pkg::SYM_A) && (item.symbol <= tsi_pkg::SYM_Z);
        is_plus  = 1'b0;
        is_minus = 1'b0;
        is_push  = 1'b0;
        is_pop   = 1'b0;
        unique case (item.symbol)
            tsi_pkg::SYM_PLUS:  is_plus  = 1'b1;
            tsi_pkg::SYM_MINUS: is_minus = 1'b1;
            tsi_pkg::SYM_PUSH:  is_push  = 1'b1;
            tsi_pkg::SYM_POP:   is_pop   = 1'b1;
            default:            ;
        endcase
    end

    assign stack_full  = (base_depth == tsi_pkg::DEPTH_W'(tsi_pkg::STACK_DEPTH));
    assign stack_empty = (base_depth == '0);

    assign stack_ctl.push = item_accept && is_push && !stack_full;
    assign stack_ctl.pop  = item_accept && is_pop && !stack_empty;

    assign push_state.x  = base_x;
    assign push_state.y  = base_y;
    assign push_state.hd = base_hd;

    // Save stack: cell 0 is the top, entries shift down on push and up on pop.
    for (genvar gi = 0; gi < tsi_pkg::STACK_DEPTH; gi++)
    begin : g_cell
        tsi_pkg::turtle_state_t above_w;
        tsi_pkg::turtle_state_t below_w;
        if (gi == 0)
        begin : g_top
            assign above_w = push_state;
        end
        else
        begin : g_mid
            assign above_w = cell_entry[gi-1];
        end
        if (gi == tsi_pkg::STACK_DEPTH - 1)
        begin : g_last
            assign below_w = '0;
        end
        else
        begin : g_inner
            assign below_w = cell_entry[gi+1];
        end
        tsi_stack_cell u_cell (
            .clk   (clk),
            .ctl   (stack_ctl),
            .above (above_w),
            .below (below_w),
            .entry (cell_entry[gi])
        );
    end

    // Next turtle state and result word
    always_comb
    begin
        pos_x_next        = pos_x_reg;
        pos_y_next        = pos_y_reg;
        heading_next      = heading_reg;
        depth_next        = depth_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg;

        if (result_valid_reg && result_ready)
        begin
            result_valid_next = 1'b0;
        end

        if (item_accept)
        begin
            pos_x_next   = base_x;
            pos_y_next   = base_y;
            heading_next = base_hd;
            depth_next   = base_depth;

            result_next.drew   = 1'b0;
            result_next.from_x = '0;
            result_next.from_y = '0;
            result_next.to_x   = '0;
            result_next.to_y   = '0;
            result_next.status = tsi_pkg::STATUS_OK;

            if (is_draw)
            begin
                pos_x_next         = new_x;
                pos_y_next         = new_y;
                result_next.drew   = 1'b1;
                result_next.from_x = base_x;
                result_next.from_y = base_y;
                result_next.to_x   = new_x;
                result_next.to_y   = new_y;
                result_next.status = sat ? tsi_pkg::STATUS_SAT : tsi_pkg::STATUS_OK;
            end
            else if (is_plus)
            begin
                heading_next = base_hd + turn_step_reg;
            end
            else if (is_minus)
            begin
                heading_next = base_hd - turn_step_reg;
            end
            else if (is_push)
            begin
                if (stack_full)
                begin
                    result_next.status = tsi_pkg::STATUS_PUSH_FULL;
                end
                else
                begin
                    depth_next = base_depth + tsi_pkg::DEPTH_W'(1);
                end
            end
            else if (is_pop)
            begin
                if (stack_empty)
                begin
                    result_next.status = tsi_pkg::STATUS_POP_EMPTY;
                end
                else
                begin
                    depth_next   = base_depth - tsi_pkg::DEPTH_W'(1);
                    pos_x_next   = cell_entry[0].x;
                    pos_y_next   = cell_entry[0].y;
                    heading_next = cell_entry[0].hd;
                end
            end

            result_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            turn_step_reg    <= tsi_pkg::TURN_STEP_RESET;
            start_x_reg      <= '0;
            start_y_reg      <= '0;
            pos_x_reg        <= '0;
            pos_y_reg        <= '0;
            heading_reg      <= '0;
            depth_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            pos_x_reg        <= pos_x_next;
            pos_y_reg        <= pos_y_next;
            heading_reg      <= heading_next;
            depth_reg        <= depth_next;
            result_valid_reg <= result_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    tsi_pkg::CFG_TURN_STEP: turn_step_reg <= cfg_data[tsi_pkg::HD_W-1:0];
                    tsi_pkg::CFG_START_X:   start_x_reg   <= cfg_data[tsi_pkg::POS_W-1:0];
                    tsi_pkg::CFG_START_Y:   start_y_reg   <= cfg_data[tsi_pkg::POS_W-1:0];
                    default:                ;
                endcase
            end
        end
    end

    // Payload of the result register; no reset needed.
    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

`ifndef ASSERT_OFF
    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= tsi_pkg::DEPTH_W'(tsi_pkg::STACK_DEPTH))
        else $error("stack depth beyond capacity");

    a_no_segment_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.drew |->
            result.from_x == '0 && result.from_y == '0 &&
            result.to_x == '0 && result.to_y == '0)
        else $error("segment fields nonzero without a segment");

    a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
        item_accept && !item.first && depth_reg == '0 && item.symbol == tsi_pkg::SYM_POP
        |=> result_valid && result.status == tsi_pkg::STATUS_POP_EMPTY)
        else $error("pop on empty stack not flagged");

    a_sat_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.status == tsi_pkg::STATUS_SAT |->
            result.drew &&
            (result.to_x == tsi_pkg::POS_MAX || result.to_x == tsi_pkg::POS_MIN ||
             result.to_y == tsi_pkg::POS_MAX || result.to_y == tsi_pkg::POS_MIN))
        else $error("saturation flagged away from a limit");
`endif

endmodule
